/* hdl/bpa_pkg.sv */
// Shared types, codes and defaults for the bitmap page allocator.
package bpa_pkg;

  localparam int PAGE_COUNT_DEF = 512;
  localparam int FRAME_BITS_DEF = 40;

  // Widest map row read per cycle, as a bit-index width (32 pages a row).
  localparam int COL_W_MAX = 5;

  localparam int STATUS_W = 2;
  localparam int PAGES_W  = 10;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_OUTSIDE   = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_ALLOC_FIN,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic row_clr;
    logic row_inc;
    logic rd_alloc;
    logic rd_free;
    logic set_full;
    logic free_range;
    logic alloc_chk;
    logic alloc_fin;
    logic free_chk;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic row_last;
    logic is_free;
    logic full;
    logic hit;
    logic outside;
    logic slot_free;
  } sts_t;

endpackage

/* hdl/bitmap_page_allocator.sv */
// Bitmap first-fit page allocator: one request in flight, map held in a row-wide RAM.
// Allocate reads then checks one map row (32 pages a row) at a time from row 0 until the
// first free page, and reports full after a scan of every row; a free reads and checks the
// row holding the page; full by count or outside goes straight to the result step.
// A stalled result register holds the result step until the register is free. After
// reset the map is cleared one row a cycle with input stalled.
module bitmap_page_allocator #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int FRAME_BITS = bpa_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [FRAME_BITS-1:0]         cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [FRAME_BITS-1:0]         frame_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpa_pkg::STATUS_W-1:0]  status_o,
  output logic [FRAME_BITS-1:0]         frame_out_o,
  output logic [bpa_pkg::PAGES_W-1:0]   pages_in_use_o
);
  import bpa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_acc;

  assign in_acc = in_valid_i & ~in_stall_o;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpa_datapath #(
    .PAGE_COUNT (PAGE_COUNT),
    .FRAME_BITS (FRAME_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_type_i     (req_type_i),
    .frame_in_i     (frame_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .frame_out_o    (frame_out_o),
    .pages_in_use_o (pages_in_use_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  // Only one request is ever in flight.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("second beat accepted while a request is in flight");

  // A single map RAM port: never two reads or two writes in one cycle.
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.rd_alloc, cmd.rd_free}) &&
    $onehot0({cmd.clr_wr, cmd.alloc_chk, cmd.free_chk}))
    else $error("map RAM port driven twice");

  // A result only ever overwrites an empty or departing output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!out_valid_o || !out_stall_i))
    else $error("pending result overwritten");

  // Only a successful allocate carries a frame.
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (frame_out_o == '0))
    else $error("frame returned with an error status");

endmodule

/* hdl/bpa_ctrl.sv */
// Controller state machine for the bitmap page allocator.
module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o
);
  import bpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.row_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        if (sts_i.is_free) begin
          state_d = sts_i.outside ? S_RESULT : S_FREE_RD;
        end else begin
          state_d = sts_i.full ? S_RESULT : S_ALLOC_CHK;
        end
      end
      S_ALLOC_RD: state_d = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        if (sts_i.hit) begin
          state_d = S_ALLOC_FIN;
        end else if (sts_i.row_last) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_ALLOC_RD;
        end
      end
      S_ALLOC_FIN: state_d = S_RESULT;
      S_FREE_RD:   state_d = S_FREE_CHK;
      S_FREE_CHK:  state_d = S_RESULT;
      S_RESULT: begin
        if (sts_i.slot_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.row_inc = ~sts_i.row_last;
        cmd_o.row_clr = sts_i.row_last;
      end
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
        cmd_o.row_clr = 1'b1;
      end
      S_START: begin
        if (sts_i.is_free) begin
          cmd_o.free_range = 1'b1;
        end else if (sts_i.full) begin
          cmd_o.set_full = 1'b1;
        end else begin
          cmd_o.rd_alloc = 1'b1;
        end
      end
      S_ALLOC_RD: cmd_o.rd_alloc = 1'b1;
      S_ALLOC_CHK: begin
        cmd_o.alloc_chk = 1'b1;
        if (!sts_i.hit) begin
          // no free page in this row: move on, or give up at the last row
          cmd_o.set_full = sts_i.row_last;
          cmd_o.row_inc  = ~sts_i.row_last;
        end
      end
      S_ALLOC_FIN: cmd_o.alloc_fin = 1'b1;
      S_FREE_RD:   cmd_o.rd_free   = 1'b1;
      S_FREE_CHK:  cmd_o.free_chk  = 1'b1;
      S_RESULT:    cmd_o.res_load  = sts_i.slot_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

/* hdl/bpa_datapath.sv */
// Datapath: allocation map memory, page counter, region checks and result register.
module bpa_datapath #(
  parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
  parameter int FRAME_BITS = bpa_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [FRAME_BITS-1:0]         cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [FRAME_BITS-1:0]         frame_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpa_pkg::STATUS_W-1:0]  status_o,
  output logic [FRAME_BITS-1:0]         frame_out_o,
  output logic [bpa_pkg::PAGES_W-1:0]   pages_in_use_o,
  input  bpa_pkg::cmd_t                 cmd_i,
  output bpa_pkg::sts_t                 sts_o
);
  import bpa_pkg::*;

  localparam int IDX_W   = $clog2(PAGE_COUNT);
  localparam int CNT_W   = $clog2(PAGE_COUNT + 1);
  localparam int COL_W   = (IDX_W < COL_W_MAX) ? IDX_W : COL_W_MAX;
  localparam int ROW_W   = 1 << COL_W;
  localparam int ROW_CNT = (PAGE_COUNT + ROW_W - 1) / ROW_W;
  localparam int ADDR_W  = (ROW_CNT > 1) ? $clog2(ROW_CNT) : 1;

  logic [FRAME_BITS-1:0] base_q;
  logic [CNT_W-1:0]      usable_q, usable_d;
  logic                  type_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [ADDR_W-1:0]     row_q;
  logic [IDX_W-1:0]      idx_q;
  logic [ROW_W-1:0]      rd_data_q;
  logic [CNT_W-1:0]      count_q;
  status_e               res_status_q;
  logic [FRAME_BITS-1:0] res_frame_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [FRAME_BITS-1:0] out_frame_q;
  logic [PAGES_W-1:0]    out_pages_q;

  logic [ROW_W-1:0]      mem_q [ROW_CNT];

  logic [FRAME_BITS:0]   room;
  logic [FRAME_BITS:0]   diff;
  logic                  outside;
  logic [ADDR_W-1:0]     idx_row;
  logic [COL_W-1:0]      idx_col;
  logic [CNT_W-1:0]      urow;
  logic [COL_W-1:0]      uoff;
  logic [CNT_W-1:0]      row_ext;
  logic [ROW_W-1:0]      avail_mask;
  logic [ROW_W-1:0]      free_vec;
  logic [ROW_W-1:0]      lowest;
  logic [COL_W-1:0]      hit_col;
  logic                  hit;
  logic                  bit_set;
  logic                  slot_free;
  logic                  row_last;
  logic                  full;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ROW_W-1:0]      wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;

  // Pages whose frame still fits in FRAME_BITS bits above the new base.
  assign room     = {1'b1, {FRAME_BITS{1'b0}}} - {1'b0, cfg_wdata_i};
  assign usable_d = (room < (FRAME_BITS + 1)'(PAGE_COUNT)) ? CNT_W'(room)
                                                           : CNT_W'(PAGE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      usable_q <= CNT_W'(PAGE_COUNT);
    end else if (cfg_we_i) begin
      base_q   <= cfg_wdata_i;
      usable_q <= usable_d;
    end
  end

  assign diff    = {1'b0, frame_q} - {1'b0, base_q};
  assign outside = diff[FRAME_BITS] || (diff[FRAME_BITS-1:0] >= FRAME_BITS'(PAGE_COUNT));
  assign idx_row = ADDR_W'(idx_q >> COL_W);
  assign idx_col = idx_q[COL_W-1:0];

  // Mask off pages at or past the usable limit in the row being scanned.
  assign urow    = usable_q >> COL_W;
  assign uoff    = usable_q[COL_W-1:0];
  assign row_ext = CNT_W'(row_q);

  always_comb begin
    if (row_ext < urow) begin
      avail_mask = '1;
    end else if (row_ext == urow) begin
      avail_mask = ~({ROW_W{1'b1}} << uoff);
    end else begin
      avail_mask = '0;
    end
  end

  assign free_vec = ~rd_data_q & avail_mask;
  assign hit      = |free_vec;
  assign lowest   = free_vec & (~free_vec + ROW_W'(1));

  always_comb begin
    hit_col = '0;
    for (int b = 0; b < ROW_W; b++) begin
      if (lowest[b]) hit_col = hit_col | COL_W'(b);
    end
  end

  assign bit_set   = rd_data_q[idx_col];
  assign row_last  = (row_q == ADDR_W'(ROW_CNT - 1));
  assign full      = (count_q == CNT_W'(PAGE_COUNT));
  assign slot_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = '0;
    if (cmd_i.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.alloc_chk && hit) begin
      wr_en   = 1'b1;
      wr_data = rd_data_q | lowest;
    end else if (cmd_i.free_chk && bit_set) begin
      wr_en   = 1'b1;
      wr_addr = idx_row;
      wr_data = rd_data_q & ~(ROW_W'(1) << idx_col);
    end
  end

  assign rd_en   = cmd_i.rd_alloc | cmd_i.rd_free;
  assign rd_addr = cmd_i.rd_free ? idx_row : row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.row_clr) begin
        row_q <= '0;
      end else if (cmd_i.row_inc) begin
        row_q <= row_q + ADDR_W'(1);
      end
      if (cmd_i.alloc_fin) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.free_chk && bit_set && (count_q != '0)) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Request capture, working index and pending result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      type_q  <= req_type_i;
      frame_q <= frame_in_i;
    end
    if (cmd_i.free_range) begin
      idx_q <= diff[IDX_W-1:0];
      if (outside) begin
        res_status_q <= STAT_OUTSIDE;
        res_frame_q  <= '0;
      end
    end else if (cmd_i.alloc_chk && hit) begin
      idx_q <= IDX_W'({row_q, hit_col});
    end
    if (cmd_i.set_full) begin
      res_status_q <= STAT_FULL;
      res_frame_q  <= '0;
    end
    if (cmd_i.alloc_fin) begin
      res_status_q <= STAT_OK;
      res_frame_q  <= base_q + FRAME_BITS'(idx_q);
    end
    if (cmd_i.free_chk) begin
      res_status_q <= bit_set ? STAT_OK : STAT_NOT_ALLOC;
      res_frame_q  <= '0;
    end
    if (cmd_i.res_load) begin
      out_status_q <= res_status_q;
      out_frame_q  <= res_frame_q;
      out_pages_q  <= PAGES_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign frame_out_o    = out_frame_q;
  assign pages_in_use_o = out_pages_q;

  assign sts_o.row_last  = row_last;
  assign sts_o.is_free   = (type_q == REQ_FREE);
  assign sts_o.full      = full;
  assign sts_o.hit       = hit;
  assign sts_o.outside   = outside;
  assign sts_o.slot_free = slot_free;

endmodule
